@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

@@ hw/rtl/wavp_pkg.sv @@
// Shared types and constants of the WAV header parser.
package wavp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [1:0] KIND_FORMAT = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_NO_RIFF   = 4'd1;
  localparam logic [3:0] ST_NO_FMT    = 4'd2;
  localparam logic [3:0] ST_NOT_PCM   = 4'd3;
  localparam logic [3:0] ST_CHANNELS  = 4'd4;
  localparam logic [3:0] ST_WIDTH     = 4'd5;
  localparam logic [3:0] ST_NO_DATA   = 4'd6;
  localparam logic [3:0] ST_ZERO_SIZE = 4'd7;
  localparam logic [3:0] ST_TRUNC     = 4'd8;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  status;
    logic [1:0]  channels;
    logic [4:0]  sample_bits;
    logic [31:0] sample_rate;
    logic [30:0] data_size;
    logic [7:0]  sample_byte;
    logic        last;
  } wavp_result_t;

endpackage

@@ hw/rtl/wavp_front.sv @@
// Byte classifier and chunk walker: turns each accepted byte into at most one result.
`include "assert_macros.svh"
module wavp_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  logic [7:0]            in_byte,
  input  logic                  end_of_file,
  output logic                  res_valid,
  output wavp_pkg::wavp_result_t res
);
  import wavp_pkg::*;

  localparam logic [2:0] PH_TOP_HDR  = 3'd0;
  localparam logic [2:0] PH_TOP_SKIP = 3'd1;
  localparam logic [2:0] PH_WAVE     = 3'd2;
  localparam logic [2:0] PH_SUB_HDR  = 3'd3;
  localparam logic [2:0] PH_SUB_SKIP = 3'd4;
  localparam logic [2:0] PH_FMT      = 3'd5;
  localparam logic [2:0] PH_DATA     = 3'd6;
  localparam logic [2:0] PH_IDLE     = 3'd7;

  logic [2:0]  phase, phase_next;
  logic [3:0]  header_count, header_count_next;
  logic [31:0] chunk_tag, chunk_tag_next;
  logic [31:0] chunk_length, chunk_length_next;
  logic [31:0] skip_left, skip_left_next;
  logic        format_seen, format_seen_next;
  logic [1:0]  kept_channels, kept_channels_next;
  logic [1:0]  kept_width, kept_width_next;
  logic [31:0] kept_rate, kept_rate_next;
  logic [30:0] data_left, data_left_next;

  logic [31:0] tag_shift, len_shift, hdr_tag, hdr_len, pad_len, skip_dec;
  logic [3:0]  hc_inc;
  logic        hdr_done;
  logic [15:0] hi_half;
  logic [12:0] width_code;
  logic [30:0] data_dec;
  logic        err;
  logic [3:0]  err_code;
  logic [3:0]  eof_code;

  assign tag_shift  = {in_byte, chunk_tag[31:8]};
  assign len_shift  = {in_byte, chunk_length[31:8]};
  assign hc_inc     = header_count + 4'd1;
  assign hdr_done   = (hc_inc >= 4'd8);
  assign hdr_tag    = (header_count < 4'd4) ? tag_shift : chunk_tag;
  assign hdr_len    = (header_count < 4'd4) ? chunk_length : len_shift;
  assign pad_len    = (hdr_len + 32'd1) & ~32'd1;
  assign skip_dec   = skip_left - 32'd1;
  assign hi_half    = tag_shift[31:16];
  assign width_code = tag_shift[31:19];
  assign data_dec   = data_left - 31'd1;

  always_comb begin
    phase_next         = phase;
    header_count_next  = header_count;
    chunk_tag_next     = chunk_tag;
    chunk_length_next  = chunk_length;
    skip_left_next     = skip_left;
    format_seen_next   = format_seen;
    kept_channels_next = kept_channels;
    kept_width_next    = kept_width;
    kept_rate_next     = kept_rate;
    data_left_next     = data_left;
    res_valid          = 1'b0;
    res                = '0;
    err                = 1'b0;
    err_code           = ST_OK;
    eof_code           = ST_TRUNC;
    if (take) begin
      case (phase)
        PH_TOP_HDR, PH_SUB_HDR: begin
          chunk_tag_next    = hdr_tag;
          chunk_length_next = hdr_len;
          header_count_next = hdr_done ? 4'd0 : hc_inc;
          if (hdr_done) begin
            if (phase == PH_TOP_HDR) begin
              if (hdr_len[31]) begin
                err = 1'b1; err_code = ST_NO_RIFF;
              end else if (hdr_tag == TAG_RIFF) begin
                phase_next = PH_WAVE;
              end else begin
                skip_left_next = pad_len;
                phase_next = (pad_len != 32'd0) ? PH_TOP_SKIP : PH_TOP_HDR;
              end
            end else begin
              if (hdr_len[31]) begin
                err = 1'b1; err_code = format_seen ? ST_NO_DATA : ST_NO_FMT;
              end else if (hdr_tag == TAG_DATA) begin
                if (!format_seen) begin
                  err = 1'b1; err_code = ST_NO_FMT;
                end else if (hdr_len == 32'd0) begin
                  err = 1'b1; err_code = ST_ZERO_SIZE;
                end else begin
                  data_left_next    = hdr_len[30:0];
                  res_valid         = 1'b1;
                  res.kind          = KIND_FORMAT;
                  res.channels      = kept_channels;
                  res.sample_bits   = {kept_width, 3'b000};
                  res.sample_rate   = kept_rate;
                  res.data_size     = hdr_len[30:0];
                  phase_next        = PH_DATA;
                end
              end else if (hdr_tag == TAG_FMT && !format_seen) begin
                skip_left_next = (pad_len > 32'd16) ? pad_len - 32'd16 : 32'd0;
                phase_next = PH_FMT;
              end else begin
                skip_left_next = pad_len;
                phase_next = (pad_len != 32'd0) ? PH_SUB_SKIP : PH_SUB_HDR;
              end
            end
          end
        end
        PH_TOP_SKIP, PH_SUB_SKIP: begin
          skip_left_next = skip_dec;
          if (skip_dec == 32'd0) begin
            phase_next = (phase == PH_TOP_SKIP) ? PH_TOP_HDR : PH_SUB_HDR;
          end
        end
        PH_WAVE: begin
          chunk_tag_next    = tag_shift;
          header_count_next = hc_inc;
          if (hc_inc >= 4'd4) begin
            header_count_next = 4'd0;
            if (tag_shift == TAG_WAVE) begin
              phase_next = PH_SUB_HDR;
            end else begin
              err = 1'b1; err_code = ST_NO_RIFF;
            end
          end
        end
        PH_FMT: begin
          chunk_tag_next    = tag_shift;
          header_count_next = hc_inc;
          case (header_count)
            4'd1: begin
              if (hi_half != 16'd1) begin
                err = 1'b1; err_code = ST_NOT_PCM;
              end
            end
            4'd3: begin
              if (hi_half != 16'd1 && hi_half != 16'd2) begin
                err = 1'b1; err_code = ST_CHANNELS;
              end else begin
                kept_channels_next = hi_half[1:0];
              end
            end
            4'd7: kept_rate_next = tag_shift;
            4'd15: begin
              header_count_next = 4'd0;
              if (width_code != 13'd1 && width_code != 13'd2) begin
                err = 1'b1; err_code = ST_WIDTH;
              end else begin
                kept_width_next  = width_code[1:0];
                format_seen_next = 1'b1;
                phase_next = (skip_left != 32'd0) ? PH_SUB_SKIP : PH_SUB_HDR;
              end
            end
            default: ;
          endcase
        end
        PH_DATA: begin
          data_left_next  = data_dec;
          res_valid       = 1'b1;
          res.kind        = KIND_SAMPLE;
          res.sample_byte = in_byte;
          if (data_dec == 31'd0) begin
            res.last   = 1'b1;
            phase_next = PH_IDLE;
          end
        end
        default: phase_next = PH_IDLE;
      endcase

      if (err) begin
        res        = '0;
        res.kind   = KIND_ERROR;
        res.status = err_code;
        res.last   = 1'b1;
        res_valid  = 1'b1;
        phase_next = PH_IDLE;
      end

      if (end_of_file) begin
        // an early end replaces whatever this byte produced, but an error result stands
        if (!err && phase_next != PH_IDLE) begin
          if ((phase_next == PH_TOP_HDR && header_count_next == 4'd0) ||
              phase_next == PH_TOP_SKIP) begin
            eof_code = ST_NO_RIFF;
          end else if ((phase_next == PH_SUB_HDR && header_count_next == 4'd0) ||
                       phase_next == PH_SUB_SKIP) begin
            eof_code = format_seen_next ? ST_NO_DATA : ST_NO_FMT;
          end
          res        = '0;
          res.kind   = KIND_ERROR;
          res.status = eof_code;
          res.last   = 1'b1;
          res_valid  = 1'b1;
        end
        phase_next         = PH_TOP_HDR;
        header_count_next  = 4'd0;
        chunk_tag_next     = 32'd0;
        chunk_length_next  = 32'd0;
        skip_left_next     = 32'd0;
        format_seen_next   = 1'b0;
        kept_channels_next = 2'd0;
        kept_width_next    = 2'd0;
        kept_rate_next     = 32'd0;
        data_left_next     = 31'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_TOP_HDR;
      header_count  <= 4'd0;
      chunk_tag     <= 32'd0;
      chunk_length  <= 32'd0;
      skip_left     <= 32'd0;
      format_seen   <= 1'b0;
      kept_channels <= 2'd0;
      kept_width    <= 2'd0;
      kept_rate     <= 32'd0;
      data_left     <= 31'd0;
    end else begin
      phase         <= phase_next;
      header_count  <= header_count_next;
      chunk_tag     <= chunk_tag_next;
      chunk_length  <= chunk_length_next;
      skip_left     <= skip_left_next;
      format_seen   <= format_seen_next;
      kept_channels <= kept_channels_next;
      kept_width    <= kept_width_next;
      kept_rate     <= kept_rate_next;
      data_left     <= data_left_next;
    end
  end

  `ASSERT_PROP(a_skip_nonzero, clk, rst,
    (phase == PH_TOP_SKIP || phase == PH_SUB_SKIP) |-> (skip_left != 32'd0),
    "skip phase entered with nothing left to skip")
  `ASSERT_PROP(a_eof_restart, clk, rst,
    (take && end_of_file) |=> (phase == PH_TOP_HDR && header_count == 4'd0),
    "parser did not restart after end of file")
  `ASSERT_PROP(a_error_last, clk, rst,
    (res_valid && res.kind == KIND_ERROR) |-> (res.last && phase_next != PH_DATA),
    "error result without last or with sample transfer continuing")

endmodule

@@ hw/rtl/wavp_queue.sv @@
// Result queue between the byte classifier and the result port.
`include "assert_macros.svh"
module wavp_queue #(
  parameter int DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  wavp_pkg::wavp_result_t wr_data,
  output logic                   full,
  output logic                   empty,
  input  logic                   rd_en,
  output wavp_pkg::wavp_result_t rd_data
);
  import wavp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  wavp_result_t     store [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  `ASSERT_PROP(a_count_max, clk, rst, count <= CNT_W'(DEPTH),
    "queue count beyond depth")
  `ASSERT_PROP(a_hold_full, clk, rst, (full && !rd_en) |=> full,
    "full queue changed without a transfer out")
  `ASSERT_NEVER(a_ptr_gap, clk, rst,
    (empty || full) && (wr_ptr != rd_ptr),
    "pointers disagree with count")

endmodule

@@ hw/rtl/wav_header_parser.sv @@
// Top level of the streaming WAV header parser.
// A result is registered into the result queue as its byte transfers in and is shown at the queue head.
// Throughput: one byte per cycle while the DEPTH-entry result queue has room;
//   full rises when it holds DEPTH results that have not been popped.
// Reset: synchronous rst returns the chunk walker to the RIFF search and empties
//   the queue; there is no clearing pass.
module wav_header_parser #(
  parameter int DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  input  logic        end_of_file,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [3:0]  status,
  output logic [1:0]  channels,
  output logic [4:0]  sample_bits,
  output logic [31:0] sample_rate,
  output logic [30:0] data_size,
  output logic [7:0]  sample_byte,
  output logic        last
);
  import wavp_pkg::*;

  logic         take;
  logic         res_valid;
  wavp_result_t res;
  wavp_result_t head;

  assign take = push && !full;

  wavp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .in_byte     (in_byte),
    .end_of_file (end_of_file),
    .res_valid   (res_valid),
    .res         (res)
  );

  wavp_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_valid),
    .wr_data (res),
    .full    (full),
    .empty   (empty),
    .rd_en   (pop),
    .rd_data (head)
  );

  assign kind        = head.kind;
  assign status      = head.status;
  assign channels    = head.channels;
  assign sample_bits = head.sample_bits;
  assign sample_rate = head.sample_rate;
  assign data_size   = head.data_size;
  assign sample_byte = head.sample_byte;
  assign last        = head.last;

endmodule

@@ test/tb_wav_header_parser.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the WAV header parser: byte stream in, parse results out.
module tb_wav_header_parser;
  import wavp_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_BYTES   = 500;
  localparam int DRAIN_CYCLES   = 10;

  typedef enum logic [2:0] {
    WALK_TOP_HDR,
    WALK_TOP_SKIP,
    WALK_WAVE,
    WALK_SUB_HDR,
    WALK_SUB_SKIP,
    WALK_FMT,
    WALK_DATA,
    WALK_DONE
  } walk_phase_t;

  typedef enum logic [1:0] {
    RX_STREAM,
    RX_COIN,
    RX_PATTERN,
    RX_TRICKLE
  } rx_mode_t;

  typedef struct packed {
    logic [7:0] value;
    logic       eof;
  } stream_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic [7:0]  in_byte = 8'h00;
  logic        end_of_file = 1'b0;
  logic        pop = 1'b0;
  logic        full;
  logic        empty;
  logic [1:0]  kind;
  logic [3:0]  status;
  logic [1:0]  channels;
  logic [4:0]  sample_bits;
  logic [31:0] sample_rate;
  logic [30:0] data_size;
  logic [7:0]  sample_byte;
  logic        last;

  wav_header_parser u_dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .in_byte(in_byte),
    .end_of_file(end_of_file),
    .empty(empty),
    .pop(pop),
    .kind(kind),
    .status(status),
    .channels(channels),
    .sample_bits(sample_bits),
    .sample_rate(sample_rate),
    .data_size(data_size),
    .sample_byte(sample_byte),
    .last(last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  stream_byte_t byte_stream[$];
  logic [7:0]   file_buf[$];
  wavp_result_t results_due[$];
  stream_byte_t next_byte;
  wavp_result_t want;
  int           mismatches = 0;

  // Parser model state
  walk_phase_t walk;
  logic [3:0]  hdr_idx;
  logic [31:0] tag_acc;
  logic [31:0] len_acc;
  logic [31:0] skip_left;
  logic        fmt_seen;
  logic [1:0]  chan_kept;
  logic [1:0]  width_kept;
  logic [31:0] rate_kept;
  logic [30:0] data_left;

  function automatic logic [31:0] pad_even(input logic [31:0] n);
    logic [31:0] s;
    s = n + 32'd1;
    return s & ~32'd1;
  endfunction

  task automatic reset_parser();
    walk       = WALK_TOP_HDR;
    hdr_idx    = '0;
    tag_acc    = '0;
    len_acc    = '0;
    skip_left  = '0;
    fmt_seen   = 1'b0;
    chan_kept  = '0;
    width_kept = '0;
    rate_kept  = '0;
    data_left  = '0;
  endtask

  // Shift one header byte in; true once tag and length are complete.
  function automatic logic shift_header(input logic [7:0] b);
    if (hdr_idx < 4'd4) tag_acc = {b, tag_acc[31:8]};
    else len_acc = {b, len_acc[31:8]};
    hdr_idx = hdr_idx + 4'd1;
    if (hdr_idx >= 4'd8) begin
      hdr_idx = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic wavp_result_t error_result(input logic [3:0] code);
    wavp_result_t r;
    r = '0;
    r.kind = KIND_ERROR;
    r.status = code;
    r.last = 1'b1;
    walk = WALK_DONE;
    return r;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic eof);
    wavp_result_t r;
    logic         have;
    logic         err;
    logic [31:0]  v;
    logic [3:0]   idx;
    logic [3:0]   code;
    r = '0;
    have = 1'b0;
    err = 1'b0;
    case (walk)
      WALK_TOP_HDR: begin
        if (shift_header(b)) begin
          if (len_acc[31]) begin
            r = error_result(ST_NO_RIFF);
            have = 1'b1;
            err = 1'b1;
          end else if (tag_acc == TAG_RIFF) begin
            walk = WALK_WAVE;
          end else begin
            skip_left = pad_even(len_acc);
            walk = (skip_left != 0) ? WALK_TOP_SKIP : WALK_TOP_HDR;
          end
        end
      end
      WALK_TOP_SKIP, WALK_SUB_SKIP: begin
        skip_left = skip_left - 32'd1;
        if (skip_left == 0) walk = (walk == WALK_TOP_SKIP) ? WALK_TOP_HDR : WALK_SUB_HDR;
      end
      WALK_WAVE: begin
        tag_acc = {b, tag_acc[31:8]};
        hdr_idx = hdr_idx + 4'd1;
        if (hdr_idx >= 4'd4) begin
          hdr_idx = '0;
          if (tag_acc == TAG_WAVE) begin
            walk = WALK_SUB_HDR;
          end else begin
            r = error_result(ST_NO_RIFF);
            have = 1'b1;
            err = 1'b1;
          end
        end
      end
      WALK_SUB_HDR: begin
        if (shift_header(b)) begin
          if (len_acc[31]) begin
            r = error_result(fmt_seen ? ST_NO_DATA : ST_NO_FMT);
            have = 1'b1;
            err = 1'b1;
          end else if (tag_acc == TAG_DATA) begin
            have = 1'b1;
            if (!fmt_seen) begin
              r = error_result(ST_NO_FMT);
              err = 1'b1;
            end else if (len_acc == 0) begin
              r = error_result(ST_ZERO_SIZE);
              err = 1'b1;
            end else begin
              data_left = len_acc[30:0];
              r.kind = KIND_FORMAT;
              r.status = ST_OK;
              r.channels = chan_kept;
              r.sample_bits = {width_kept, 3'b000};
              r.sample_rate = rate_kept;
              r.data_size = data_left;
              walk = WALK_DATA;
            end
          end else if (tag_acc == TAG_FMT && !fmt_seen) begin
            v = pad_even(len_acc);
            skip_left = (v > 32'd16) ? v - 32'd16 : 32'd0;
            walk = WALK_FMT;
          end else begin
            skip_left = pad_even(len_acc);
            walk = (skip_left != 0) ? WALK_SUB_SKIP : WALK_SUB_HDR;
          end
        end
      end
      WALK_FMT: begin
        tag_acc = {b, tag_acc[31:8]};
        idx = hdr_idx;
        hdr_idx = idx + 4'd1;
        if (idx == 4'd1) begin
          if (tag_acc[31:16] != 16'd1) begin
            r = error_result(ST_NOT_PCM);
            have = 1'b1;
            err = 1'b1;
          end
        end else if (idx == 4'd3) begin
          v = {16'd0, tag_acc[31:16]};
          if (v != 32'd1 && v != 32'd2) begin
            r = error_result(ST_CHANNELS);
            have = 1'b1;
            err = 1'b1;
          end else begin
            chan_kept = v[1:0];
          end
        end else if (idx == 4'd7) begin
          rate_kept = tag_acc;
        end else if (idx == 4'd15) begin
          v = {16'd0, tag_acc[31:16]} >> 3;
          hdr_idx = '0;
          if (v != 32'd1 && v != 32'd2) begin
            r = error_result(ST_WIDTH);
            have = 1'b1;
            err = 1'b1;
          end else begin
            width_kept = v[1:0];
            fmt_seen = 1'b1;
            walk = (skip_left != 0) ? WALK_SUB_SKIP : WALK_SUB_HDR;
          end
        end
      end
      WALK_DATA: begin
        r.kind = KIND_SAMPLE;
        r.sample_byte = b;
        data_left = data_left - 31'd1;
        if (data_left == 0) begin
          r.last = 1'b1;
          walk = WALK_DONE;
        end
        have = 1'b1;
      end
      default: walk = WALK_DONE;
    endcase

    if (eof) begin
      if (!err && walk != WALK_DONE) begin
        if ((walk == WALK_TOP_HDR && hdr_idx == 0) || walk == WALK_TOP_SKIP)
          code = ST_NO_RIFF;
        else if ((walk == WALK_SUB_HDR && hdr_idx == 0) || walk == WALK_SUB_SKIP)
          code = fmt_seen ? ST_NO_DATA : ST_NO_FMT;
        else
          code = ST_TRUNC;
        r = error_result(code);
        have = 1'b1;
      end
      reset_parser();
    end
    if (have) results_due.push_back(r);
  endtask

  task automatic report(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] exp_v);
    if (got !== exp_v) report($sformatf("%s got 0x%0h, want 0x%0h", name, got, exp_v));
  endtask

  // File assembly
  task automatic add_u8(input logic [7:0] b);
    file_buf.push_back(b);
  endtask

  task automatic add_u16(input logic [15:0] v);
    add_u8(v[7:0]);
    add_u8(v[15:8]);
  endtask

  task automatic add_u32(input logic [31:0] v);
    add_u16(v[15:0]);
    add_u16(v[31:16]);
  endtask

  // Move the assembled file to the stream, optionally cut short; mark its final byte.
  task automatic commit_file(input logic cut_short);
    int unsigned keep;
    keep = file_buf.size();
    if (cut_short) keep = $urandom_range(1, keep);
    for (int unsigned i = 0; i < keep; i++) byte_stream.push_back({file_buf[i], i == keep - 1});
    file_buf.delete();
  endtask

  task automatic add_filler_chunk();
    logic [31:0] n;
    n = $urandom_range(0, 5);
    add_u32($urandom);
    add_u32(n);
    repeat (pad_even(n)) add_u8(8'($urandom));
  endtask

  task automatic build_directed();
    // Stereo 16-bit at the top rate, extreme samples, end of file on the last one.
    add_u32(TAG_RIFF);
    add_u32(32'd38);
    add_u32(TAG_WAVE);
    add_u32(TAG_FMT);
    add_u32(32'd16);
    add_u16(16'd1);
    add_u16(16'd2);
    add_u32(32'hFFFF_FFFF);
    add_u32(32'h0000_0000);
    add_u16(16'd4);
    add_u16(16'd16);
    add_u32(TAG_DATA);
    add_u32(32'd2);
    add_u8(8'hFF);
    add_u8(8'h00);
    commit_file(1'b0);
    // File of one byte
    add_u8(8'h00);
    commit_file(1'b0);
    // Top-level chunk with a negative length, then a byte to drop
    add_u32(32'h4B4E_554A);
    add_u32(32'h8000_0000);
    add_u8(8'hA5);
    commit_file(1'b0);
  endtask

  task automatic build_random_file();
    logic [31:0] flen;
    logic [31:0] dlen;
    logic [31:0] rate;
    logic [31:0] padded_len;
    logic [15:0] fmt_code;
    logic [15:0] chans;
    logic [15:0] bits;
    int unsigned nsamp;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 16)) add_u8(8'($urandom));
      commit_file(1'b0);
      return;
    end
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) add_filler_chunk();
    add_u32(($urandom_range(15) == 0) ? $urandom : TAG_RIFF);
    add_u32(($urandom_range(19) == 0) ? ($urandom | 32'h8000_0000) : ($urandom & 32'h7FFF_FFFF));
    add_u32(($urandom_range(15) == 0) ? $urandom : TAG_WAVE);
    if ($urandom_range(3) == 0) add_filler_chunk();
    // Data header ahead of fmt
    if ($urandom_range(19) == 0) begin
      add_u32(TAG_DATA);
      add_u32(32'd4);
    end
    case ($urandom_range(7))
      0: flen = $urandom_range(10, 15);
      1: flen = $urandom_range(17, 24);
      2: flen = ($urandom_range(3) == 0) ? ($urandom | 32'h8000_0000) : 32'd18;
      default: flen = 32'd16;
    endcase
    fmt_code = ($urandom_range(11) == 0) ? 16'($urandom) : 16'd1;
    if ($urandom_range(11) == 0)
      chans = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(3));
    else
      chans = $urandom_range(1) ? 16'd1 : 16'd2;
    if ($urandom_range(11) == 0) bits = 16'($urandom);
    else bits = $urandom_range(1) ? 16'd8 : 16'd16;
    case ($urandom_range(7))
      0: rate = 32'h0000_0000;
      1: rate = 32'hFFFF_FFFF;
      default: rate = $urandom;
    endcase
    add_u32(TAG_FMT);
    add_u32(flen);
    add_u16(fmt_code);
    add_u16(chans);
    add_u32(rate);
    add_u32($urandom);
    add_u16(16'($urandom));
    add_u16(bits);
    padded_len = pad_even(flen);
    if (!flen[31] && padded_len > 32'd16) repeat (padded_len - 32'd16) add_u8(8'($urandom));
    // A later fmt chunk is skipped
    if ($urandom_range(5) == 0) begin
      add_u32(TAG_FMT);
      add_u32(32'd16);
      repeat (16) add_u8(8'($urandom));
    end
    if ($urandom_range(3) == 0) add_filler_chunk();
    case ($urandom_range(15))
      0: dlen = 32'd0;
      1: dlen = 32'h7FFF_FFFF;
      2: dlen = $urandom;
      default: dlen = $urandom_range(1, 8);
    endcase
    add_u32(TAG_DATA);
    add_u32(dlen);
    nsamp = (dlen <= 32'd8) ? dlen : $urandom_range(1, 6);
    repeat (nsamp) add_u8(8'($urandom));
    repeat ($urandom_range(2)) add_u8(8'($urandom));
    commit_file($urandom_range(4) == 0);
  endtask

  // Sender: bursts of transfers separated by random gaps
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
      reset_parser();
    end else begin
      if (push && !full) parse_byte(in_byte, end_of_file);
      if (!push || !full) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          push <= 1'b0;
        end else if (byte_stream.size() != 0) begin
          next_byte = byte_stream.pop_front();
          push <= 1'b1;
          in_byte <= next_byte.value;
          end_of_file <= next_byte.eof;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 32);
            gap_left <= ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall on a changing mix of modes
  rx_mode_t    rx_mode;
  int unsigned rx_left;
  logic [15:0] rx_pattern;

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      rx_mode <= RX_STREAM;
      rx_left <= 0;
      rx_pattern <= 16'hFFFF;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= rx_mode_t'($urandom_range(3));
        rx_left <= $urandom_range(8, 64);
        rx_pattern <= 16'($urandom);
      end else begin
        rx_left <= rx_left - 1;
        rx_pattern <= {rx_pattern[14:0], rx_pattern[15]};
      end
      case (rx_mode)
        RX_STREAM:  pop <= 1'b1;
        RX_COIN:    pop <= 1'($urandom_range(1));
        RX_PATTERN: pop <= rx_pattern[15];
        default:    pop <= ($urandom_range(7) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (results_due.size() == 0) begin
        report($sformatf("result with nothing pending: kind %0d status %0d", kind, status));
      end else begin
        want = results_due.pop_front();
        check_field("kind", 32'(kind), 32'(want.kind));
        check_field("status", 32'(status), 32'(want.status));
        check_field("channels", 32'(channels), 32'(want.channels));
        check_field("sample_bits", 32'(sample_bits), 32'(want.sample_bits));
        check_field("sample_rate", sample_rate, want.sample_rate);
        check_field("data_size", 32'(data_size), 32'(want.data_size));
        check_field("sample_byte", 32'(sample_byte), 32'(want.sample_byte));
        check_field("last", 32'(last), 32'(want.last));
      end
    end
  end

  // Watchdog: restart on any transfer
  int unsigned idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    int unsigned target;
    build_directed();
    target = byte_stream.size() + RANDOM_BYTES;
    while (byte_stream.size() < target) build_random_file();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    while (byte_stream.size() != 0 || push || results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
